>>> sv/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for rotation matrix to quaternion
// Fixed-point format, pipeline payload structs for the sqrt and divide chains.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned VW        = 36;   // signed width of the unnormalized vector
  localparam int unsigned MW        = 31;   // magnitude width after range shift
  localparam int unsigned SW        = 64;   // sum of squares width
  localparam int unsigned RW        = 32;   // root width
  localparam int unsigned DW        = 64;   // divider remainder width
  localparam int unsigned NCELL     = 32;   // cells in each chain

  typedef logic [MW-1:0] mag_t;

  typedef struct packed {
    logic             deg;
    logic [3:0]       neg;
    logic [3:0][MW-1:0] mag;
  } lane_t;

  typedef struct packed {
    logic          valid;
    lane_t         lane;
    logic [SW-1:0] rem;
    logic [RW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic               valid;
    logic               deg;
    logic [3:0]         neg;
    logic [RW-1:0]      den;
    logic [3:0][DW-1:0] rem;
    logic [3:0][RW-1:0] quo;
  } div_t;

endpackage

>>> sv/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion
// Shepperd branch select, then v/|v| through a square root cell chain and a
// divide cell chain, fully pipelined.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------------
//   request  | start / busy     | r00_i .. r22_i, signed Q2.30
//   result   | done_o (strobe)  | quat_w_o .. quat_z_o, degenerate_o
//
// One request per cycle; busy is always low. A request passes through four
// front stages, 32 square root cells, 32 divide cells and the output register.
// Reset clears the valid bits of every stage; requests in flight are dropped.
// The receiver cannot stall, so results leave on done_o as they finish.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] r00_i,
  input  logic signed [31:0] r01_i,
  input  logic signed [31:0] r02_i,
  input  logic signed [31:0] r10_i,
  input  logic signed [31:0] r11_i,
  input  logic signed [31:0] r12_i,
  input  logic signed [31:0] r20_i,
  input  logic signed [31:0] r21_i,
  input  logic signed [31:0] r22_i,
  output logic               done_o,
  output logic signed [31:0] quat_w_o,
  output logic signed [31:0] quat_x_o,
  output logic signed [31:0] quat_y_o,
  output logic signed [31:0] quat_z_o,
  output logic               degenerate_o
);
  import rmq_pkg::*;

  sqrt_t sq [NCELL+1];
  div_t  dc [NCELL+1];

  logic [RW-1:0]  n;
  logic [30:0]    mg [4];
  logic [31:0]    q_d [4];
  logic [31:0]    q_q [4];
  logic           deg_q, done_q;

  assign busy = 1'b0;

  rmq_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (start & ~busy),
    .r00_i  (r00_i),
    .r01_i  (r01_i),
    .r02_i  (r02_i),
    .r10_i  (r10_i),
    .r11_i  (r11_i),
    .r12_i  (r12_i),
    .r20_i  (r20_i),
    .r21_i  (r21_i),
    .r22_i  (r22_i),
    .out_o  (sq[0])
  );

  for (genvar j = 0; j < NCELL; j++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (5'(NCELL - 1 - j)),
      .in_i   (sq[j]),
      .out_o  (sq[j+1])
    );
  end

  // numerator is mag * 2^frac plus half the norm for rounding
  always_comb begin
    n            = (sq[NCELL].root == '0) ? RW'(1) : sq[NCELL].root;
    dc[0].valid  = sq[NCELL].valid;
    dc[0].deg    = sq[NCELL].lane.deg;
    dc[0].neg    = sq[NCELL].lane.neg;
    dc[0].den    = n;
    for (int i = 0; i < 4; i++) begin
      dc[0].rem[i] = (DW'(sq[NCELL].lane.mag[i]) << FRAC_BITS) + DW'(n >> 1);
      dc[0].quo[i] = '0;
    end
  end

  for (genvar j = 0; j < NCELL; j++) begin : g_div
    rmq_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (5'(NCELL - 1 - j)),
      .in_i   (dc[j]),
      .out_o  (dc[j+1])
    );
  end

  // top quotient bit set means the magnitude saturates
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mg[i]  = dc[NCELL].quo[i][31] ? 31'h7FFF_FFFF : dc[NCELL].quo[i][30:0];
      q_d[i] = dc[NCELL].neg[i] ? -{1'b0, mg[i]} : {1'b0, mg[i]};
      if (dc[NCELL].deg) q_d[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dc[NCELL].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q <= dc[NCELL].deg;
    for (int i = 0; i < 4; i++) q_q[i] <= q_d[i];
  end

  assign done_o       = done_q;
  assign degenerate_o = deg_q;
  assign quat_w_o     = q_q[0];
  assign quat_x_o     = q_q[1];
  assign quat_y_o     = q_q[2];
  assign quat_z_o     = q_q[3];

endmodule

>>> sv/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front: branch select, vector build, range shift and sum of squares
// Four registered stages ahead of the square root chain.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_i,
  input  logic signed [31:0]   r00_i,
  input  logic signed [31:0]   r01_i,
  input  logic signed [31:0]   r02_i,
  input  logic signed [31:0]   r10_i,
  input  logic signed [31:0]   r11_i,
  input  logic signed [31:0]   r12_i,
  input  logic signed [31:0]   r20_i,
  input  logic signed [31:0]   r21_i,
  input  logic signed [31:0]   r22_i,
  output rmq_pkg::sqrt_t       out_o
);
  import rmq_pkg::*;

  localparam logic signed [VW-1:0] One = VW'(64'd1 << FRAC_BITS);

  logic signed [VW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [VW-1:0] tr, rad;
  logic signed [VW-1:0] v_d [4];
  logic signed [VW-1:0] v_q [4];
  logic                 deg1_q, vld1_q;

  logic [VW-2:0]        mabs [4];
  logic [VW-2:0]        orr;
  logic [MW-1:0]        m_d [4];
  logic [MW-1:0]        m_q [4];
  logic [3:0]           neg2_q;
  logic                 deg2_q, vld2_q;

  logic [2*MW-1:0]      sq_q [4];
  logic [MW-1:0]        m3_q [4];
  logic [3:0]           neg3_q;
  logic                 deg3_q, vld3_q;

  logic [SW-1:0]        sum_q;
  logic [MW-1:0]        m4_q [4];
  logic [3:0]           neg4_q;
  logic                 deg4_q, vld4_q;

  assign a00 = VW'(r00_i);
  assign a01 = VW'(r01_i);
  assign a02 = VW'(r02_i);
  assign a10 = VW'(r10_i);
  assign a11 = VW'(r11_i);
  assign a12 = VW'(r12_i);
  assign a20 = VW'(r20_i);
  assign a21 = VW'(r21_i);
  assign a22 = VW'(r22_i);
  assign tr  = a00 + a11 + a22;

  always_comb begin
    priority if (tr > 0) begin
      rad    = tr + One;
      v_d[0] = rad;       v_d[1] = a21 - a12; v_d[2] = a02 - a20; v_d[3] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      rad    = One + a00 - a11 - a22;
      v_d[0] = a21 - a12; v_d[1] = rad;       v_d[2] = a01 + a10; v_d[3] = a02 + a20;
    end else if (a11 > a22) begin
      rad    = One + a11 - a00 - a22;
      v_d[0] = a02 - a20; v_d[1] = a01 + a10; v_d[2] = rad;       v_d[3] = a12 + a21;
    end else begin
      rad    = One + a22 - a00 - a11;
      v_d[0] = a10 - a01; v_d[1] = a02 + a20; v_d[2] = a12 + a21; v_d[3] = rad;
    end
  end

  // range shift: smallest k that brings the largest magnitude below 2^31
  always_comb begin
    orr = '0;
    for (int i = 0; i < 4; i++) begin
      mabs[i] = v_q[i][VW-1] ? (VW-1)'(-v_q[i]) : v_q[i][VW-2:0];
      orr     = orr | mabs[i];
    end
    for (int i = 0; i < 4; i++) begin
      priority if (orr[VW-2:MW] == '0) begin
        m_d[i] = mabs[i][MW-1:0];
      end else if (orr[VW-2:MW+1] == '0) begin
        m_d[i] = mabs[i][MW:1];
      end else if (orr[VW-2:MW+2] == '0) begin
        m_d[i] = mabs[i][MW+1:2];
      end else begin
        m_d[i] = mabs[i][MW+2:3];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= req_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    deg1_q <= (rad <= 0);
    deg2_q <= deg1_q;
    deg3_q <= deg2_q;
    deg4_q <= deg3_q;
    neg3_q <= neg2_q;
    neg4_q <= neg3_q;
    sum_q  <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
    for (int i = 0; i < 4; i++) begin
      v_q[i]    <= v_d[i];
      m_q[i]    <= m_d[i];
      neg2_q[i] <= v_q[i][VW-1];
      sq_q[i]   <= m_q[i] * m_q[i];
      m3_q[i]   <= m_q[i];
      m4_q[i]   <= m3_q[i];
    end
  end

  always_comb begin
    out_o.valid    = vld4_q;
    out_o.lane.deg = deg4_q;
    out_o.lane.neg = neg4_q;
    for (int i = 0; i < 4; i++) out_o.lane.mag[i] = m4_q[i];
    out_o.rem      = sum_q;
    out_o.root     = '0;
  end

endmodule

>>> sv/rmq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rmq_sqrt_cell: one root bit of the integer square root chain
// Tries root bit idx against the running remainder and passes the result on.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [4:0]     idx_i,
  input  rmq_pkg::sqrt_t in_i,
  output rmq_pkg::sqrt_t out_o
);
  import rmq_pkg::*;

  logic [SW+1:0] trial;
  sqrt_t         d;
  logic          valid_q;
  sqrt_t         pl_q;

  always_comb begin
    trial = ((SW+2)'(in_i.root) << ({1'b0, idx_i} + 6'd1)) | ((SW+2)'(1) << {idx_i, 1'b0});
    d     = in_i;
    if ({2'b0, in_i.rem} >= trial) begin
      d.rem  = in_i.rem - trial[SW-1:0];
      d.root = in_i.root | (RW'(1) << idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= d;
  end

  always_comb begin
    out_o       = pl_q;
    out_o.valid = valid_q;
  end

endmodule

>>> sv/rmq_div_cell.sv
// ----------------------------------------------------------------------------
// rmq_div_cell: one quotient bit for all four lanes of the normalizing divide
// Restoring step against the norm shifted up by idx.
// ----------------------------------------------------------------------------
module rmq_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [4:0]    idx_i,
  input  rmq_pkg::div_t in_i,
  output rmq_pkg::div_t out_o
);
  import rmq_pkg::*;

  logic [DW-1:0] dv;
  div_t          d;
  logic          valid_q;
  div_t          pl_q;

  always_comb begin
    dv = DW'(in_i.den) << idx_i;
    d  = in_i;
    for (int i = 0; i < 4; i++) begin
      if (in_i.rem[i] >= dv) begin
        d.rem[i] = in_i.rem[i] - dv;
        d.quo[i] = in_i.quo[i] | (RW'(1) << idx_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= d;
  end

  always_comb begin
    out_o       = pl_q;
    out_o.valid = valid_q;
  end

endmodule
